// ===== design/slc_pkg.sv =====
// Shared types and constants for the sprite line compositor.
// No dependencies; the CSR interface, sprite store, line buffer and top level refer to it by scoped names.
package slc_pkg;

   localparam int TILE_PIXELS = 8;
   localparam int ROW_BITS    = 2 * TILE_PIXELS;
   localparam int CSR_IDX_W   = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_OBJECTS_ENABLED = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PALETTE_ZERO    = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PALETTE_ONE     = 8'd2;

   typedef struct packed {
      logic [7:0] sprite_x;
      logic       mirror_x;
      logic       palette_pick;
      logic       behind_flag;
      logic [7:0] plane_low;
      logic [7:0] plane_high;
   } sprite_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear;
   } buf_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAW_RD,
      ST_DRAW_WR,
      ST_EMIT_RD,
      ST_EMIT_LOAD,
      ST_EMIT_WAIT
   } state_type;

endpackage

// ===== design/slc_req_if.sv =====
// Input channel of the sprite line compositor: one sprite and/or line end per transfer.
// Independent of the package.
interface slc_req_if;
   logic       valid;
   logic       ready;
   logic       object_present;
   logic [7:0] sprite_x;
   logic       mirror_x;
   logic       palette_pick;
   logic       behind_flag;
   logic [7:0] plane_low;
   logic [7:0] plane_high;
   logic       line_end;

   modport source (output valid, object_present, sprite_x, mirror_x, palette_pick,
                   behind_flag, plane_low, plane_high, line_end, input ready);
   modport sink   (input valid, object_present, sprite_x, mirror_x, palette_pick,
                   behind_flag, plane_low, plane_high, line_end, output ready);
endinterface

// ===== design/slc_rsp_if.sv =====
// Result channel of the sprite line compositor: one group of eight pixels per transfer.
// Independent of the package.
interface slc_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  group_index;
   logic [15:0] group_pixels;
   logic        group_last;

   modport source (output valid, group_index, group_pixels, group_last, input ready);
   modport sink   (input valid, group_index, group_pixels, group_last, output ready);
endinterface

// ===== design/slc_csr_if.sv =====
// Register write channel of the sprite line compositor.
// Uses slc_pkg for the index width.
interface slc_csr_if;
   logic                          valid;
   logic                          ready;
   logic [slc_pkg::CSR_IDX_W-1:0] index;
   logic [7:0]                    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/slc_sprite_store.sv =====
// Sprite store: one write port, one registered read port.
// Uses slc_pkg::sprite_type.
module slc_sprite_store #(
   parameter int DEPTH = 10,
   parameter int AW    = 4
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  slc_pkg::sprite_type wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output slc_pkg::sprite_type rd_data
);

   slc_pkg::sprite_type mem [DEPTH];
   slc_pkg::sprite_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/slc_line_buffer.sv =====
// Line buffer: rows of eight 2-bit pixels, registered read, per-row valid bits.
// Invalid rows read as zero; clear drops all valid bits at once. Uses slc_pkg.
module slc_line_buffer #(
   parameter int ROWS = 20,
   parameter int RA_W = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  slc_pkg::buf_ctl_type          ctl,
   input  logic [RA_W-1:0]               addr,
   input  logic [slc_pkg::ROW_BITS-1:0]  wr_data,
   output logic [slc_pkg::ROW_BITS-1:0]  rd_data
);

   logic [slc_pkg::ROW_BITS-1:0] mem [ROWS];
   logic [ROWS-1:0]              row_valid_ff;
   logic [ROWS-1:0]              row_valid_in;
   logic [slc_pkg::ROW_BITS-1:0] rd_raw_ff;
   logic                         rd_ok_ff;

   always_comb begin
      row_valid_in = row_valid_ff;
      if (ctl.clear) begin
         row_valid_in = '0;
      end else if (ctl.wr_en) begin
         row_valid_in[addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else begin
         row_valid_ff <= row_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_raw_ff <= mem[addr];
         rd_ok_ff  <= row_valid_ff[addr];
      end
   end

   assign rd_data = rd_ok_ff ? rd_raw_ff : '0;

endmodule

// ===== design/sprite_line_compositor.sv =====
// Sprite line compositor, top level: input sequencing, draw-order scan, pixel
// draw and group emission. Uses slc_pkg, the channel interfaces, the sprite store
// and the line buffer.
//
// Usage: each req transfer may load one sprite (object_present) into the store and
// may end the line (line_end). A sprite beyond MAX_SPRITES in one line is dropped.
// A transfer without line_end produces nothing. On line_end the stored sprites are
// drawn in descending sprite_x order (earlier loaded first on equal x) by one shared
// key compare: each sprite costs a scan over the store plus eight read-modify-write
// pixel steps (a hidden sprite skips the pixel steps), and a final scan ends the
// pass. With objects disabled no drawing is done. The line then leaves on rsp as
// (LINE_WIDTH+7)/8 groups, one at a time; a stalled receiver holds the group in the
// output register and the block waits. req_ready is low from line_end until the
// cycle after the last group transfers; the buffer and sprite count are then cleared.
// csr writes are always taken (csr_ready high). Reset (synchronous) clears the
// control registers, the sprite count and the line buffer valid bits; the store and
// the payload registers are not cleared.
module sprite_line_compositor #(
   parameter int MAX_SPRITES = 10,
   parameter int LINE_WIDTH  = 160,
   parameter int X_OFFSET    = 8
) (
   input logic      clock,
   input logic      reset,
   slc_req_if.sink  req_if,
   slc_rsp_if.source rsp_if,
   slc_csr_if.sink  csr_if
);

   localparam int ROWS  = (LINE_WIDTH + slc_pkg::TILE_PIXELS - 1) / slc_pkg::TILE_PIXELS;
   localparam int RA_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int SA_W  = (MAX_SPRITES > 1) ? $clog2(MAX_SPRITES) : 1;
   localparam int CNT_W = $clog2(MAX_SPRITES + 1);
   localparam int KEY_W = 8 + SA_W;
   localparam int POS_W = 10;

   slc_pkg::state_type state_ff, state_in;

   logic             enabled_ff;
   logic [7:0]       pal0_ff, pal1_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [SA_W-1:0]  rd_idx_ff;
   logic [KEY_W-1:0] last_key_ff, best_key_ff;
   logic             have_last_ff, best_found_ff;
   slc_pkg::sprite_type best_ff;
   logic [2:0]       t_ff;
   logic [RA_W-1:0]  grp_ff;

   logic             rsp_valid_ff;
   logic [4:0]       rsp_index_ff;
   logic [15:0]      rsp_pixels_ff;
   logic             rsp_last_ff;

   logic                 accept;
   logic                 store_wr;
   slc_pkg::sprite_type  store_wdata, store_rdata;
   logic                 store_rd;
   slc_pkg::buf_ctl_type buf_ctl;
   logic [RA_W-1:0]      buf_addr;
   logic [15:0]          buf_wdata, buf_rdata;

   logic [KEY_W-1:0] cand_key;
   logic             cand_take;
   logic             scan_done;
   logic             hidden;
   logic [POS_W-1:0] pos_raw, pos;
   logic             on_line;
   logic [2:0]       sh;
   logic [1:0]       pix_idx, colour, cur;
   logic [7:0]       pal;
   logic [3:0]       shamt;
   logic             pix_write;
   logic             grp_last;

   assign accept   = req_if.valid && req_if.ready;
   assign store_wr = accept && req_if.object_present && (count_ff < CNT_W'(MAX_SPRITES));
   assign store_wdata = '{sprite_x:     req_if.sprite_x,
                          mirror_x:     req_if.mirror_x,
                          palette_pick: req_if.palette_pick,
                          behind_flag:  req_if.behind_flag,
                          plane_low:    req_if.plane_low,
                          plane_high:   req_if.plane_high};

   // draw-order key: larger x first, lower store index first on ties
   assign cand_key  = {~store_rdata.sprite_x, rd_idx_ff};
   assign cand_take = rd_vld_ff && (!have_last_ff || cand_key > last_key_ff)
                      && (!best_found_ff || cand_key < best_key_ff);
   assign scan_done = (scan_ff == count_ff) && !rd_vld_ff;
   assign hidden    = (best_ff.sprite_x == 8'd0)
                      || ({2'b00, best_ff.sprite_x} >= POS_W'(LINE_WIDTH + X_OFFSET));

   assign pos_raw = {2'b00, best_ff.sprite_x} + {7'd0, t_ff};
   assign pos     = pos_raw - POS_W'(X_OFFSET);
   assign on_line = (pos_raw >= POS_W'(X_OFFSET)) && (pos < POS_W'(LINE_WIDTH));
   assign sh      = best_ff.mirror_x ? t_ff : 3'd7 - t_ff;
   assign pix_idx = {best_ff.plane_high[sh], best_ff.plane_low[sh]};
   assign pal     = best_ff.palette_pick ? pal1_ff : pal0_ff;
   assign colour  = 2'(pal >> {pix_idx, 1'b0});
   assign shamt   = {3'd7 - pos[2:0], 1'b0};
   assign cur     = 2'(buf_rdata >> shamt);
   assign pix_write = on_line && (pix_idx != 2'd0) && !(best_ff.behind_flag && cur != 2'd0);
   assign buf_wdata = (buf_rdata & ~(16'h3 << shamt)) | ({14'd0, colour} << shamt);
   assign grp_last  = (grp_ff == RA_W'(ROWS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         slc_pkg::ST_IDLE: begin
            if (accept && req_if.line_end) begin
               state_in = enabled_ff ? slc_pkg::ST_SCAN : slc_pkg::ST_EMIT_RD;
            end
         end
         slc_pkg::ST_SCAN: begin
            if (scan_done) begin
               if (!best_found_ff) begin
                  state_in = slc_pkg::ST_EMIT_RD;
               end else if (!hidden) begin
                  state_in = slc_pkg::ST_DRAW_RD;
               end
            end
         end
         slc_pkg::ST_DRAW_RD: state_in = slc_pkg::ST_DRAW_WR;
         slc_pkg::ST_DRAW_WR: begin
            state_in = (t_ff == 3'd7) ? slc_pkg::ST_SCAN : slc_pkg::ST_DRAW_RD;
         end
         slc_pkg::ST_EMIT_RD: state_in = slc_pkg::ST_EMIT_LOAD;
         slc_pkg::ST_EMIT_LOAD: state_in = slc_pkg::ST_EMIT_WAIT;
         slc_pkg::ST_EMIT_WAIT: begin
            if (rsp_if.ready) begin
               state_in = rsp_last_ff ? slc_pkg::ST_IDLE : slc_pkg::ST_EMIT_RD;
            end
         end
         default: state_in = slc_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      store_rd  = 1'b0;
      rd_vld_in = 1'b0;
      scan_in   = scan_ff;
      buf_ctl   = '0;
      buf_addr  = grp_ff;
      count_in  = count_ff;
      if (store_wr) begin
         count_in = count_ff + CNT_W'(1);
      end
      case (state_ff)
         slc_pkg::ST_SCAN: begin
            if (scan_ff != count_ff) begin
               store_rd  = 1'b1;
               rd_vld_in = 1'b1;
               scan_in   = scan_ff + CNT_W'(1);
            end else if (scan_done) begin
               scan_in = '0;
            end
         end
         slc_pkg::ST_DRAW_RD: begin
            buf_ctl.rd_en = 1'b1;
            buf_addr      = pos[3 +: RA_W];
         end
         slc_pkg::ST_DRAW_WR: begin
            buf_ctl.wr_en = pix_write;
            buf_addr      = pos[3 +: RA_W];
         end
         slc_pkg::ST_EMIT_RD: buf_ctl.rd_en = 1'b1;
         slc_pkg::ST_EMIT_WAIT: begin
            if (rsp_if.ready && rsp_last_ff) begin
               buf_ctl.clear = 1'b1;
               count_in      = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= slc_pkg::ST_IDLE;
         enabled_ff   <= 1'b0;
         pal0_ff      <= '0;
         pal1_ff      <= '0;
         count_ff     <= '0;
         scan_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         have_last_ff <= 1'b0;
         best_found_ff <= 1'b0;
         t_ff         <= '0;
         grp_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         scan_ff   <= scan_in;
         rd_vld_ff <= rd_vld_in;
         if (csr_if.valid) begin
            case (csr_if.index)
               slc_pkg::CSR_OBJECTS_ENABLED: enabled_ff <= csr_if.data[0];
               slc_pkg::CSR_PALETTE_ZERO:    pal0_ff    <= csr_if.data;
               slc_pkg::CSR_PALETTE_ONE:     pal1_ff    <= csr_if.data;
               default: ;
            endcase
         end
         if (state_ff == slc_pkg::ST_IDLE) begin
            have_last_ff  <= 1'b0;
            best_found_ff <= 1'b0;
            grp_ff        <= '0;
         end
         if (state_ff == slc_pkg::ST_SCAN) begin
            if (cand_take) begin
               best_found_ff <= 1'b1;
            end
            if (scan_done && best_found_ff) begin
               have_last_ff  <= 1'b1;
               best_found_ff <= 1'b0;
               t_ff          <= '0;
            end
         end
         if (state_ff == slc_pkg::ST_DRAW_WR) begin
            t_ff <= t_ff + 3'd1;
         end
         if (state_ff == slc_pkg::ST_EMIT_LOAD) begin
            rsp_valid_ff <= 1'b1;
         end
         if (state_ff == slc_pkg::ST_EMIT_WAIT && rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
            if (!rsp_last_ff) begin
               grp_ff <= grp_ff + RA_W'(1);
            end
         end
      end
   end

   // payload registers; the index tracks the returning store read
   always_ff @(posedge clock) begin
      rd_idx_ff <= scan_ff[SA_W-1:0];
      if (state_ff == slc_pkg::ST_SCAN && cand_take) begin
         best_key_ff <= cand_key;
         best_ff     <= store_rdata;
      end
      if (state_ff == slc_pkg::ST_SCAN && scan_done && best_found_ff) begin
         last_key_ff <= best_key_ff;
      end
      if (state_ff == slc_pkg::ST_EMIT_LOAD) begin
         rsp_index_ff  <= 5'(grp_ff);
         rsp_pixels_ff <= buf_rdata;
         rsp_last_ff   <= grp_last;
      end
   end

   slc_sprite_store #(
      .DEPTH (MAX_SPRITES),
      .AW    (SA_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (count_ff[SA_W-1:0]),
      .wr_data (store_wdata),
      .rd_en   (store_rd),
      .rd_addr (scan_ff[SA_W-1:0]),
      .rd_data (store_rdata)
   );

   slc_line_buffer #(
      .ROWS (ROWS),
      .RA_W (RA_W)
   ) u_buf (
      .clock   (clock),
      .reset   (reset),
      .ctl     (buf_ctl),
      .addr    (buf_addr),
      .wr_data (buf_wdata),
      .rd_data (buf_rdata)
   );

   assign req_if.ready        = (state_ff == slc_pkg::ST_IDLE);
   assign csr_if.ready        = 1'b1;
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.group_index  = rsp_index_ff;
   assign rsp_if.group_pixels = rsp_pixels_ff;
   assign rsp_if.group_last   = rsp_last_ff;

endmodule

// ===== design/slc_checker.sv =====
// Port-level checks for the sprite line compositor, bound to the top level.
// Depends only on the top level's ports.
module slc_checker #(
   parameter int LINE_WIDTH = 160
) (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [4:0]  group_index,
   input logic [15:0] group_pixels,
   input logic        group_last
);

   localparam int GROUPS = (LINE_WIDTH + 7) / 8;

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(group_index)
         && $stable(group_pixels) && $stable(group_last))
      else $error("stalled result changed");

   // no new item is taken while a group is pending
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input ready while a group is pending");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(group_index) < GROUPS)
         && (group_last == (32'(group_index) == GROUPS - 1)))
      else $error("group index or last flag out of line");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !group_last |=> !req_ready)
      else $error("block idle before the last group");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && group_last |=> req_ready)
      else $error("block not idle after the last group");

endmodule

bind sprite_line_compositor slc_checker #(
   .LINE_WIDTH (LINE_WIDTH)
) u_slc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .group_index  (rsp_if.group_index),
   .group_pixels (rsp_if.group_pixels),
   .group_last   (rsp_if.group_last)
);

// ===== verif/sprite_line_compositor_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sprite_line_compositor: queued sprite/line-end transfers,
// a line-compositing predictor and an in-order checker of the emitted pixel groups.
// Depends on slc_pkg, the slc_req_if, slc_rsp_if and slc_csr_if interfaces and the RTL.
module sprite_line_compositor_tb;

   localparam int MAX_SPR   = 10;
   localparam int LINE_W    = 160;
   localparam int X_OFF     = 8;
   localparam int GROUPS    = (LINE_W + 7) / 8;
   localparam int LIMIT     = 1000000;
   localparam int PER_PHASE = 50;

   // writes to these are expected to be dropped
   localparam logic [slc_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED_LO = 8'd3;
   localparam logic [slc_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED_HI = 8'hFF;

   typedef struct packed {
      logic                 object_present;
      slc_pkg::sprite_type  spr;
      logic                 line_end;
   } line_item_type;

   typedef struct packed {
      logic [4:0]  index;
      logic [15:0] pixels;
      logic        last;
   } group_type;

   logic clock;
   logic reset;

   slc_req_if req_if ();
   slc_rsp_if rsp_if ();
   slc_csr_if csr_if ();

   sprite_line_compositor #(
      .MAX_SPRITES(MAX_SPR),
      .LINE_WIDTH (LINE_W),
      .X_OFFSET   (X_OFF)
   ) u_top (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if),
      .csr_if(csr_if)
   );

   line_item_type pending[$];
   group_type     expected_groups[$];
   int            mismatches = 0;
   int            cycles = 0;
   bit            steady = 0;

   // shadow of the block: registers, loaded sprites, line under construction
   logic                objs_on  = 1'b0;
   logic [7:0]          pal_zero = 8'h00;
   logic [7:0]          pal_one  = 8'h00;
   slc_pkg::sprite_type sprites[MAX_SPR];
   int                  sprite_count = 0;
   logic [1:0]          line_px[LINE_W] = '{default: 2'b00};

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic flag_mismatch(string what);
      mismatches++;
      $display("MISMATCH cycle %0d: %s", cycles, what);
   endtask

   // Load a sprite and, on a line end, composite the line and queue its groups.
   function automatic void take_item(line_item_type it);
      int                  i, k, t, pos, best, col, g, p;
      logic                used[MAX_SPR];
      slc_pkg::sprite_type s;
      logic [1:0]          code;
      logic [7:0]          pal;
      logic [15:0]         word;
      if (it.object_present && sprite_count < MAX_SPR) begin
         sprites[sprite_count] = it.spr;
         sprite_count++;
      end
      if (!it.line_end) return;
      if (objs_on) begin
         for (i = 0; i < MAX_SPR; i++) used[i] = 1'b0;
         // largest x first, earliest loaded wins ties, so it is painted first
         for (k = 0; k < sprite_count; k++) begin
            best = -1;
            for (i = 0; i < sprite_count; i++) begin
               if (!used[i] && (best < 0 || sprites[i].sprite_x > sprites[best].sprite_x))
                  best = i;
            end
            used[best] = 1'b1;
            s = sprites[best];
            pal = s.palette_pick ? pal_one : pal_zero;
            if (s.sprite_x != 0 && s.sprite_x < LINE_W + X_OFF) begin
               for (t = 0; t < 8; t++) begin
                  pos = int'(s.sprite_x) - X_OFF + t;
                  col = s.mirror_x ? 7 - t : t;
                  code = {s.plane_high[7 - col], s.plane_low[7 - col]};
                  if (pos >= 0 && pos < LINE_W && code != 2'd0) begin
                     if (!(s.behind_flag && line_px[pos] != 2'd0))
                        line_px[pos] = pal[2 * code +: 2];
                  end
               end
            end
         end
      end
      for (g = 0; g < GROUPS; g++) begin
         word = '0;
         for (p = 0; p < 8; p++)
            word = {word[13:0], (g * 8 + p < LINE_W) ? line_px[g * 8 + p] : 2'b00};
         expected_groups.push_back('{index: g[4:0], pixels: word, last: g == GROUPS - 1});
      end
      for (i = 0; i < LINE_W; i++) line_px[i] = 2'b00;
      sprite_count = 0;
   endfunction

   // request driver
   always @(posedge clock) begin : drive_req
      line_item_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (pending.size() != 0 && (steady || $urandom_range(99) >= 35)) begin
            nxt = pending.pop_front();
            req_if.valid          <= 1'b1;
            req_if.object_present <= nxt.object_present;
            req_if.sprite_x       <= nxt.spr.sprite_x;
            req_if.mirror_x       <= nxt.spr.mirror_x;
            req_if.palette_pick   <= nxt.spr.palette_pick;
            req_if.behind_flag    <= nxt.spr.behind_flag;
            req_if.plane_low      <= nxt.spr.plane_low;
            req_if.plane_high     <= nxt.spr.plane_high;
            req_if.line_end       <= nxt.line_end;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_if.ready <= !reset && (steady || $urandom_range(99) >= 35);
   end

   // monitor: predict on accepted requests, check accepted groups
   always @(posedge clock) begin : watch
      line_item_type seen;
      group_type     got, want;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            seen.object_present   = req_if.object_present;
            seen.spr.sprite_x     = req_if.sprite_x;
            seen.spr.mirror_x     = req_if.mirror_x;
            seen.spr.palette_pick = req_if.palette_pick;
            seen.spr.behind_flag  = req_if.behind_flag;
            seen.spr.plane_low    = req_if.plane_low;
            seen.spr.plane_high   = req_if.plane_high;
            seen.line_end         = req_if.line_end;
            take_item(seen);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{index: rsp_if.group_index, pixels: rsp_if.group_pixels,
                    last: rsp_if.group_last};
            if (expected_groups.size() == 0) begin
               flag_mismatch($sformatf("unexpected group idx=%0d pix=%h last=%b",
                                       got.index, got.pixels, got.last));
            end else begin
               want = expected_groups.pop_front();
               if (got != want)
                  flag_mismatch($sformatf("group idx=%0d/%0d pix=%h/%h last=%b/%b (got/exp)",
                                          got.index, want.index, got.pixels, want.pixels,
                                          got.last, want.last));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // wait for all transfers to drain and the block to go quiet
   task automatic settle();
      @(posedge clock);
      while (pending.size() != 0 || req_if.valid) @(posedge clock);
      while (expected_groups.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic csr_put(logic [slc_pkg::CSR_IDX_W-1:0] idx, logic [7:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      case (idx)
         slc_pkg::CSR_OBJECTS_ENABLED: objs_on  = data[0];
         slc_pkg::CSR_PALETTE_ZERO:    pal_zero = data;
         slc_pkg::CSR_PALETTE_ONE:     pal_one  = data;
         default: ;
      endcase
   endtask

   task automatic set_regs(logic en, logic [7:0] p0, logic [7:0] p1);
      csr_put(slc_pkg::CSR_OBJECTS_ENABLED, {7'($urandom_range(127)), en});
      csr_put(slc_pkg::CSR_PALETTE_ZERO, p0);
      csr_put($urandom_range(1) ? CSR_UNMAPPED_LO : CSR_UNMAPPED_HI,
              8'($urandom_range(255)));
      csr_put(slc_pkg::CSR_PALETTE_ONE, p1);
      csr_if.valid <= 1'b0;
   endtask

   function automatic line_item_type mk(logic [7:0] x, logic mir, logic pick, logic bh,
                                        logic [7:0] lo, logic [7:0] hi, logic ends);
      line_item_type it;
      it.object_present   = 1'b1;
      it.spr.sprite_x     = x;
      it.spr.mirror_x     = mir;
      it.spr.palette_pick = pick;
      it.spr.behind_flag  = bh;
      it.spr.plane_low    = lo;
      it.spr.plane_high   = hi;
      it.line_end         = ends;
      return it;
   endfunction

   function automatic logic [7:0] pick_plane();
      int r;
      r = $urandom_range(9);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hFF;
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [7:0] pick_x(bit narrow, logic [7:0] base);
      int r;
      r = $urandom_range(99);
      if (narrow && r < 80) return 8'(base + $urandom_range(12));
      if (r < 70) return 8'($urandom_range(167, 1));
      if (r < 80) return 8'($urandom_range(7, 0));
      if (r < 90) return 8'($urandom_range(175, 160));
      return 8'($urandom_range(255));
   endfunction

   function automatic line_item_type rand_sprite(logic [7:0] x, logic ends);
      return mk(x, 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom_range(99) < 30,
                pick_plane(), pick_plane(), ends);
   endfunction

   initial begin : stimulus
      int            ph, n, k, sent;
      bit            narrow;
      logic [7:0]    base;
      line_item_type it;

      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.object_present = 1'b0;
      req_if.sprite_x = '0;
      req_if.mirror_x = 1'b0;
      req_if.palette_pick = 1'b0;
      req_if.behind_flag = 1'b0;
      req_if.plane_low = '0;
      req_if.plane_high = '0;
      req_if.line_end = 1'b0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.data = '0;
      sent = 0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      settle();

      // objects disabled: line stays blank despite a sprite
      set_regs(1'b0, 8'hE4, 8'h1B);
      pending.push_back(mk(8'd80, 1'b0, 1'b0, 1'b0, 8'hFF, 8'hFF, 1'b1));
      sent++;
      settle();

      // edges, clipping, behind, tie order, full store; palette one maps all to colour 0
      set_regs(1'b1, 8'hE4, 8'h00);
      pending.push_back(mk(8'd1,   1'b0, 1'b0, 1'b0, 8'hFF, 8'h00, 1'b0));
      pending.push_back(mk(8'd7,   1'b1, 1'b0, 1'b0, 8'hAA, 8'h55, 1'b0));
      pending.push_back(mk(8'd8,   1'b0, 1'b1, 1'b1, 8'hFF, 8'hFF, 1'b0));
      pending.push_back(mk(8'd167, 1'b0, 1'b0, 1'b0, 8'hF0, 8'h0F, 1'b0));
      pending.push_back(mk(8'd161, 1'b1, 1'b0, 1'b0, 8'h3C, 8'hC3, 1'b0));
      pending.push_back(mk(8'd0,   1'b0, 1'b0, 1'b0, 8'hFF, 8'hFF, 1'b0));
      it = mk(8'd0, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
      it.object_present = 1'b0;
      pending.push_back(it);
      pending.push_back(mk(8'd168, 1'b0, 1'b0, 1'b0, 8'hFF, 8'hFF, 1'b0));
      pending.push_back(mk(8'd20,  1'b0, 1'b0, 1'b0, 8'hFF, 8'hFF, 1'b0));
      pending.push_back(mk(8'd16,  1'b0, 1'b0, 1'b1, 8'h0F, 8'hF0, 1'b0));
      pending.push_back(mk(8'd16,  1'b1, 1'b1, 1'b0, 8'hAA, 8'h00, 1'b0));
      pending.push_back(mk(8'd40,  1'b0, 1'b0, 1'b0, 8'hFF, 8'hFF, 1'b0));
      pending.push_back(mk(8'd60,  1'b0, 1'b0, 1'b0, 8'hFF, 8'hFF, 1'b1));
      pending.push_back(mk(8'd255, 1'b0, 1'b0, 1'b0, 8'hFF, 8'hFF, 1'b0));
      pending.push_back(mk(8'd100, 1'b1, 1'b0, 1'b0, 8'h81, 8'h7E, 1'b1));
      it = mk(8'hFF, 1'b1, 1'b1, 1'b1, 8'hFF, 8'hFF, 1'b1);
      it.object_present = 1'b0;
      pending.push_back(it);
      sent += 15;
      settle();

      for (ph = 0; ph < 8; ph++) begin
         case (ph)
            0: set_regs(1'b1, 8'hFF, 8'h00);
            1: set_regs(1'b1, 8'h00, 8'hFF);
            2: set_regs(1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)));
            default: set_regs($urandom_range(9) != 0, 8'($urandom_range(255)),
                              8'($urandom_range(255)));
         endcase
         steady = (ph == 4);
         while (sent < 16 + PER_PHASE * (ph + 1)) begin
            n = ($urandom_range(99) < 85) ? $urandom_range(10) : $urandom_range(13, 11);
            narrow = $urandom_range(99) < 30;
            base = 8'($urandom_range(160, 1));
            for (k = 0; k < n; k++) begin
               if ($urandom_range(99) < 10) begin
                  it = rand_sprite(8'($urandom_range(255)), 1'b0);
                  it.object_present = 1'b0;
                  pending.push_back(it);
                  sent++;
               end
               pending.push_back(rand_sprite(pick_x(narrow, base), 1'b0));
            end
            it = rand_sprite(pick_x(narrow, base), 1'b1);
            it.object_present = 1'($urandom_range(1));
            pending.push_back(it);
            sent += n + 1;
         end
         settle();
      end
      steady = 0;

      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
